// ===== hdl/ipv4v_pkg.sv =====
// Shared types and character constants for the IPv4 dotted-quad text validator.
// No dependencies; used by every module under hdl.
`default_nettype none

package ipv4v_pkg;

  // Field and state widths.
  localparam int TEXT_BYTE_W = 8;
  localparam int CHAR_CNT_W  = 4;
  localparam int DOT_CNT_W   = 3;
  localparam int DIGIT_CNT_W = 2;
  localparam int SEG_VAL_W   = 10;

  typedef logic [TEXT_BYTE_W-1:0] text_byte_t;
  typedef logic [CHAR_CNT_W-1:0]  char_cnt_t;
  typedef logic [DOT_CNT_W-1:0]   dot_cnt_t;
  typedef logic [DIGIT_CNT_W-1:0] digit_cnt_t;
  typedef logic [SEG_VAL_W-1:0]   seg_val_t;

  // Character codes and limits.
  localparam text_byte_t CHR_NUL  = 8'h00;
  localparam text_byte_t CHR_DOT  = 8'h2E;
  localparam text_byte_t CHR_ZERO = 8'h30;
  localparam text_byte_t CHR_NINE = 8'h39;
  localparam seg_val_t   OCTET_MAX = 10'd255;
  localparam dot_cnt_t   DOTS_IN_QUAD = 3'd3;
  localparam digit_cnt_t MAX_DIGITS   = 2'd3;

  // Verdict handed from the scanner to the output buffer.
  typedef struct packed {
    logic valid;
    logic legal;
  } verdict_t;

endpackage

`default_nettype wire

// ===== hdl/ipv4v_scan.sv =====
// Per-byte scanner: holds the parse state of the current string and raises a verdict
// on the terminator. Depends on ipv4v_pkg.
`default_nettype none

module ipv4v_scan #(
  parameter int MAX_TEXT_LEN = 15
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 accept,
  input  wire ipv4v_pkg::text_byte_t text_byte,
  output ipv4v_pkg::verdict_t       verdict
);

  localparam ipv4v_pkg::char_cnt_t MaxLen = ipv4v_pkg::CHAR_CNT_W'(MAX_TEXT_LEN);

  logic                  failed, failed_next;
  ipv4v_pkg::char_cnt_t  char_count, char_count_next;
  ipv4v_pkg::dot_cnt_t   dot_count, dot_count_next;
  ipv4v_pkg::digit_cnt_t digit_count, digit_count_next;
  ipv4v_pkg::seg_val_t   segment_value, segment_value_next;

  logic                is_term, is_dot, is_digit;
  ipv4v_pkg::seg_val_t seg_times_ten;
  ipv4v_pkg::seg_val_t digit_val;

  // Classify the incoming character.
  assign is_term  = (text_byte == ipv4v_pkg::CHR_NUL);
  assign is_dot   = (text_byte == ipv4v_pkg::CHR_DOT);
  assign is_digit = (text_byte >= ipv4v_pkg::CHR_ZERO) && (text_byte <= ipv4v_pkg::CHR_NINE);

  // Times ten as two shifts and an add; the sum wraps to the segment width.
  assign seg_times_ten = {segment_value[6:0], 3'b000} + {segment_value[8:0], 1'b0};
  assign digit_val     = {6'b0, text_byte[3:0]};

  // Next-state and verdict logic for one item.
  always_comb begin
    failed_next        = failed;
    char_count_next    = char_count;
    dot_count_next     = dot_count;
    digit_count_next   = digit_count;
    segment_value_next = segment_value;
    verdict.valid      = 1'b0;
    verdict.legal      = !failed && (dot_count == ipv4v_pkg::DOTS_IN_QUAD) &&
                         (digit_count != '0) && (segment_value <= ipv4v_pkg::OCTET_MAX);
    if (accept) begin
      if (is_term) begin
        verdict.valid      = 1'b1;
        failed_next        = 1'b0;
        char_count_next    = '0;
        dot_count_next     = '0;
        digit_count_next   = '0;
        segment_value_next = '0;
      end else if (!failed) begin
        if (char_count >= MaxLen) begin
          failed_next = 1'b1;
        end else if (is_dot) begin
          if ((digit_count == '0) || (segment_value > ipv4v_pkg::OCTET_MAX) ||
              (dot_count >= ipv4v_pkg::DOTS_IN_QUAD)) begin
            failed_next = 1'b1;
          end else begin
            dot_count_next     = dot_count + 1'b1;
            digit_count_next   = '0;
            segment_value_next = '0;
            char_count_next    = char_count + 1'b1;
          end
        end else if (is_digit) begin
          if (digit_count >= ipv4v_pkg::MAX_DIGITS) begin
            failed_next = 1'b1;
          end else begin
            segment_value_next = seg_times_ten + digit_val;
            digit_count_next   = digit_count + 1'b1;
            char_count_next    = char_count + 1'b1;
          end
        end else begin
          failed_next = 1'b1;
        end
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      failed        <= 1'b0;
      char_count    <= '0;
      dot_count     <= '0;
      digit_count   <= '0;
      segment_value <= '0;
    end else begin
      failed        <= failed_next;
      char_count    <= char_count_next;
      dot_count     <= dot_count_next;
      digit_count   <= digit_count_next;
      segment_value <= segment_value_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A string never counts more dots than a full quad needs.
  a_dot_bound: assert property (@(posedge clk) disable iff (rst)
    dot_count <= ipv4v_pkg::DOTS_IN_QUAD)
    else $error("dot count exceeded three");

  // The character count never passes the length limit.
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    char_count <= MaxLen)
    else $error("character count exceeded the limit");

  // Every verdict leaves the parse state cleared.
  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    verdict.valid |=> (!failed && char_count == '0 && dot_count == '0 &&
                       digit_count == '0 && segment_value == '0))
    else $error("state not cleared after a verdict");
`endif

endmodule

`default_nettype wire

// ===== hdl/ipv4v_out_buf.sv =====
// Two-entry output buffer (main register plus skid) for verdicts.
// Depends on ipv4v_pkg.
`default_nettype none

module ipv4v_out_buf (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire ipv4v_pkg::verdict_t push,
  output logic                     space,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic                     out_legal
);

  logic main_valid, skid_valid;
  logic main_legal, skid_legal;
  logic pop;

  assign pop       = main_valid && out_ready;
  assign space     = !skid_valid;
  assign out_valid = main_valid;
  assign out_legal = main_legal;

  // Control: the skid entry fills only when the main entry is held.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push.valid) begin
      if (main_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        main_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

  // Payload: move the skid entry forward or load the new verdict.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        main_legal <= skid_legal;
      end
    end else if (push.valid) begin
      if (main_valid && !pop) begin
        skid_legal <= push.legal;
      end else begin
        main_legal <= push.legal;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // The skid entry is only occupied behind a held main entry.
  a_skid_order: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> main_valid)
    else $error("skid entry valid with main entry empty");

  // No verdict arrives while the buffer is full.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.valid |-> !skid_valid)
    else $error("verdict pushed into a full buffer");
`endif

endmodule

`default_nettype wire

// ===== hdl/ipv4_text_validator.sv =====
// Top level of the IPv4 dotted-quad text validator: stream ports, scanner and output buffer.
// Verdict path: a terminator's verdict is registered into the output buffer before m_axis.
// Throughput: one item per cycle; s_axis_tready drops only when both output entries are
// full, which happens after two verdicts wait unread on m_axis.
// Reset: synchronous rst clears the parse state and empties the output buffer.
// Depends on ipv4v_pkg, ipv4v_scan and ipv4v_out_buf.
`default_nettype none

module ipv4_text_validator #(
  parameter int MAX_TEXT_LEN = 15
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,   // [7:0] text_byte
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic [7:0]      m_axis_tdata    // [0] is_legal, [7:1] zero
);

  logic                accept;
  logic                space;
  logic                out_legal;
  ipv4v_pkg::verdict_t verdict;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;
  assign m_axis_tdata  = {7'b0, out_legal};

  // Character scanner.
  ipv4v_scan #(
    .MAX_TEXT_LEN(MAX_TEXT_LEN)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .text_byte(s_axis_tdata),
    .verdict  (verdict)
  );

  // Verdict output buffer.
  ipv4v_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (verdict),
    .space    (space),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_legal(out_legal)
  );

endmodule

`default_nettype wire

// ===== test/ipv4_text_validator_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ipv4_text_validator: streams address text with random idling
// on both sides and checks every verdict against a scanner kept inside the bench.
// Depends on ipv4v_pkg and the RTL under hdl.

module ipv4_text_validator_tb;

  localparam int TEXT_LIMIT   = 15;
  localparam int RANDOM_ITEMS = 1500;
  localparam int QUIET_TAIL   = 150;
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;

  // Ways in which a well-formed address is broken.
  typedef enum int {
    FLAW_ODD_BYTE,
    FLAW_DROP_CHAR,
    FLAW_EXTRA_DOT,
    FLAW_EXTRA_DIGIT,
    FLAW_EXTRA_SEGMENT,
    FLAW_SWAP_BYTE
  } flaw_e;

  logic       clk           = 1'b0;
  logic       rst           = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'd0;   // [7:0] text_byte
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;           // [0] is_legal, [7:1] zero

  ipv4v_pkg::text_byte_t text_queue[$];      // items still to be offered
  ipv4v_pkg::text_byte_t addr_text[$];       // string under construction
  bit                    legal_verdicts[$];  // verdicts still to arrive
  int                    fail_count  = 0;
  int                    cycle_count = 0;

  // Scanner state, cleared after every verdict.
  bit                    scan_failed;
  ipv4v_pkg::char_cnt_t  scan_chars;
  ipv4v_pkg::dot_cnt_t   scan_dots;
  ipv4v_pkg::digit_cnt_t scan_digits;
  ipv4v_pkg::seg_val_t   scan_value;

  ipv4_text_validator #(
    .MAX_TEXT_LEN(TEXT_LIMIT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Idling stops once the end of the stimulus is near.
  function automatic bit idling_allowed();
    return text_queue.size() > QUIET_TAIL;
  endfunction

  task automatic clear_scan();
    scan_failed = 1'b0;
    scan_chars  = '0;
    scan_dots   = '0;
    scan_digits = '0;
    scan_value  = '0;
  endtask

  // Advances the scanner by one accepted byte; a terminator yields a verdict.
  task automatic scan_text_byte(input ipv4v_pkg::text_byte_t b);
    if (b == ipv4v_pkg::CHR_NUL) begin
      legal_verdicts.push_back(!scan_failed && scan_dots == ipv4v_pkg::DOTS_IN_QUAD &&
                               scan_digits != 0 && scan_value <= ipv4v_pkg::OCTET_MAX);
      clear_scan();
    end else if (!scan_failed) begin
      if (scan_chars >= TEXT_LIMIT) begin
        scan_failed = 1'b1;
      end else if (b == ipv4v_pkg::CHR_DOT) begin
        if (scan_digits == 0 || scan_value > ipv4v_pkg::OCTET_MAX ||
            scan_dots >= ipv4v_pkg::DOTS_IN_QUAD) begin
          scan_failed = 1'b1;
        end else begin
          scan_dots   = scan_dots + 1'b1;
          scan_digits = '0;
          scan_value  = '0;
          scan_chars  = scan_chars + 1'b1;
        end
      end else if (b >= ipv4v_pkg::CHR_ZERO && b <= ipv4v_pkg::CHR_NINE) begin
        if (scan_digits >= ipv4v_pkg::MAX_DIGITS) begin
          scan_failed = 1'b1;
        end else begin
          scan_value  = ipv4v_pkg::seg_val_t'(scan_value * 10 + (b - ipv4v_pkg::CHR_ZERO));
          scan_digits = scan_digits + 1'b1;
          scan_chars  = scan_chars + 1'b1;
        end
      end else begin
        scan_failed = 1'b1;
      end
    end
  endtask

  // Appends the string under construction and its terminator to the item queue.
  task automatic queue_addr_text();
    foreach (addr_text[i]) text_queue.push_back(addr_text[i]);
    text_queue.push_back(ipv4v_pkg::CHR_NUL);
  endtask

  task automatic queue_literal(input string t);
    addr_text.delete();
    for (int i = 0; i < t.len(); i++) addr_text.push_back(t[i]);
    queue_addr_text();
  endtask

  // One segment of 1 to 3 digits, leading zeros kept, often close to 255.
  task automatic add_segment();
    int ndig;
    int value;
    int scale;
    ndig = $urandom_range(1, 3);
    if (ndig == 3 && $urandom_range(0, 1)) value = $urandom_range(245, 265);
    else value = $urandom_range(0, 10 ** ndig - 1);
    scale = (ndig == 3) ? 100 : (ndig == 2) ? 10 : 1;
    while (scale > 0) begin
      addr_text.push_back(ipv4v_pkg::text_byte_t'(ipv4v_pkg::CHR_ZERO + (value / scale) % 10));
      scale = scale / 10;
    end
  endtask

  task automatic build_quad();
    addr_text.delete();
    for (int i = 0; i < 4; i++) begin
      if (i > 0) addr_text.push_back(ipv4v_pkg::CHR_DOT);
      add_segment();
    end
  endtask

  task automatic break_quad();
    int pos;
    case (flaw_e'($urandom_range(0, 5)))
      FLAW_ODD_BYTE: begin
        pos = $urandom_range(0, addr_text.size());
        addr_text.insert(pos, ipv4v_pkg::text_byte_t'($urandom_range(1, 255)));
      end
      FLAW_DROP_CHAR: begin
        addr_text.delete($urandom_range(0, addr_text.size() - 1));
      end
      FLAW_EXTRA_DOT: begin
        pos = $urandom_range(0, addr_text.size());
        addr_text.insert(pos, ipv4v_pkg::CHR_DOT);
      end
      FLAW_EXTRA_DIGIT: begin
        pos = $urandom_range(0, addr_text.size());
        addr_text.insert(pos,
                         ipv4v_pkg::text_byte_t'(ipv4v_pkg::CHR_ZERO + $urandom_range(0, 9)));
      end
      FLAW_EXTRA_SEGMENT: begin
        addr_text.push_back(ipv4v_pkg::CHR_DOT);
        add_segment();
      end
      default: begin
        pos = $urandom_range(0, addr_text.size() - 1);
        addr_text[pos] = ipv4v_pkg::text_byte_t'($urandom_range(1, 255));
      end
    endcase
  endtask

  // Random bytes, weighted toward digits and dots.
  task automatic build_noise();
    int len;
    int roll;
    addr_text.delete();
    len = $urandom_range(0, 18);
    repeat (len) begin
      roll = $urandom_range(0, 9);
      if (roll < 4) begin
        addr_text.push_back(ipv4v_pkg::text_byte_t'(ipv4v_pkg::CHR_ZERO + $urandom_range(0, 9)));
      end else if (roll < 6) begin
        addr_text.push_back(ipv4v_pkg::CHR_DOT);
      end else begin
        addr_text.push_back(ipv4v_pkg::text_byte_t'($urandom_range(1, 255)));
      end
    end
  endtask

  // Driver: offers queued items, holds them under back-pressure, inserts idle bursts.
  int gap_left = 0;
  int gap_pct  = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) scan_text_byte(s_axis_tdata);
      if ($urandom_range(0, 99) == 0) begin
        case ($urandom_range(0, 3))
          0, 1: gap_pct = 0;
          2: gap_pct = 15;
          default: gap_pct = 50;
        endcase
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 10);
          s_axis_tvalid <= 1'b0;
        end else if (text_queue.size() > 0) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= text_queue.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted verdict and stalls the output in bursts.
  int stall_left = 0;
  int stall_pct  = 0;
  always @(posedge clk) begin
    bit expected_legal;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (legal_verdicts.size() == 0) begin
          $error("is_legal: expected no verdict, actual %0b", m_axis_tdata[0]);
          fail_count++;
        end else begin
          expected_legal = legal_verdicts.pop_front();
          if (m_axis_tdata[0] !== expected_legal) begin
            $error("is_legal: expected %0b, actual %0b", expected_legal, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[7:1] !== 7'd0) begin
            $error("pad: expected 0, actual %0h", m_axis_tdata[7:1]);
            fail_count++;
          end
        end
      end
      if ($urandom_range(0, 99) == 0) begin
        case ($urandom_range(0, 3))
          0, 1: stall_pct = 0;
          2: stall_pct = 15;
          default: stall_pct = 50;
        endcase
      end
      if (stall_left > 0) begin
        stall_left = stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (idling_allowed() && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 10);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int directed_items;
    int roll;
    clear_scan();

    // Directed strings: extremes and each rule that can fail a string.
    queue_literal("");
    queue_literal("255.255.255.255");
    queue_literal("0.0.0.0");
    queue_literal("000.01.9.10");
    queue_literal("256.1.1.1");
    queue_literal("1.2.3.256");
    queue_literal("1..2.3");
    queue_literal(".1.2.3");
    queue_literal("1.2.3.");
    queue_literal("1.2.3");
    queue_literal("1.2.3.4.5");
    queue_literal("1234.1.1.1");
    queue_literal("1.2.3.4/");
    queue_literal("9:9.9.9");
    queue_literal("255.255.255.2550");
    queue_literal("a1.2.3.4");
    directed_items = text_queue.size();

    // Mostly whole addresses, some broken ones, some noise.
    while (text_queue.size() < directed_items + RANDOM_ITEMS) begin
      roll = $urandom_range(0, 99);
      if (roll < 55) begin
        build_quad();
      end else if (roll < 85) begin
        build_quad();
        break_quad();
      end else begin
        build_noise();
      end
      queue_addr_text();
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (text_queue.size() > 0 || s_axis_tvalid) @(posedge clk);
    while (legal_verdicts.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && legal_verdicts.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
